// File: rtl/pfa_pkg.sv
// shared types, widths and codes of the paged frame allocator
package pfa_pkg;

  localparam int PS_W      = 17;
  localparam int MS_W      = 25;
  localparam int BYTES_W   = 32;
  localparam int PID_W     = 8;
  localparam int HANDLE_W  = 4;
  localparam int AGE_W     = 32;
  localparam int DIV_W     = 32;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_PAGE_SIZE   = 4096;
  localparam int DEF_MEMORY_SIZE = 1048576;

  localparam int NUM_FRAMES_DEF    = 256;
  localparam int NUM_SLOTS_DEF     = 16;
  localparam int MAX_PAGES_DEF     = 64;
  localparam int NUM_PROCESSES_DEF = 256;

  localparam logic [1:0] ACT_ALLOC    = 2'd0;
  localparam logic [1:0] ACT_FREE     = 2'd1;
  localparam logic [1:0] ACT_RUN      = 2'd2;
  localparam logic [1:0] ACT_STOP     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEMORY_SIZE = 1'd1;

  typedef enum logic [1:0] {
    KIND_EVICT = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FAIL  = 2'd2,
    KIND_ACK   = 2'd3
  } kind_t;

  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [PS_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_W-1:0]   quot;
    logic [PS_W-1:0]    rem;
  } div_rsp_t;

endpackage

// File: rtl/pfa_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
module pfa_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  pfa_pkg::div_req_t  req,
  output pfa_pkg::div_rsp_t  rsp
);

  localparam int CNT_W = $clog2(pfa_pkg::DIV_W);

  logic                       busy_r;
  logic                       done_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [pfa_pkg::DIV_W-1:0]  quot_r;
  logic [pfa_pkg::PS_W-1:0]   rem_r;
  logic [pfa_pkg::PS_W-1:0]   divisor_r;
  logic [pfa_pkg::PS_W:0]     rem_sh;
  logic [pfa_pkg::PS_W:0]     diff;
  logic                       ge;

  assign rem_sh = {rem_r, quot_r[pfa_pkg::DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, divisor_r};
  assign diff   = rem_sh - {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r    <= 1'b1;
        cnt_r     <= '0;
        quot_r    <= req.dividend;
        rem_r     <= '0;
        divisor_r <= req.divisor;
      end else if (busy_r) begin
        quot_r <= {quot_r[pfa_pkg::DIV_W-2:0], ge};
        rem_r  <= ge ? diff[pfa_pkg::PS_W-1:0] : rem_sh[pfa_pkg::PS_W-1:0];
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(pfa_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

// File: rtl/paged_frame_allocator_evict.sv
// paged frame allocator with fifo free list and oldest-first eviction
// allocate: divides the bytes by the page size, maps each page; over max pages it fails
//   each eviction releases the victim's pages first; results wait while out_stall is high
// free: releases the handle's pages (none for an idle handle); running marks: set or cleared
// the next transfer is taken back in idle; reset loads 4096-byte pages, 1 MiB, full free list
// a configuration write rebuilds the state while no item is taken
module paged_frame_allocator_evict #(
  parameter int NUM_FRAMES    = pfa_pkg::NUM_FRAMES_DEF,
  parameter int NUM_SLOTS     = pfa_pkg::NUM_SLOTS_DEF,
  parameter int MAX_PAGES     = pfa_pkg::MAX_PAGES_DEF,
  parameter int NUM_PROCESSES = pfa_pkg::NUM_PROCESSES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_action,
  input  logic [pfa_pkg::BYTES_W-1:0]     in_request_bytes,
  input  logic [pfa_pkg::PID_W-1:0]       in_process_id,
  input  logic [pfa_pkg::HANDLE_W-1:0]    in_handle_in,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfa_pkg::MS_W-1:0]        cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_kind,
  output logic [pfa_pkg::HANDLE_W-1:0]    out_handle_out,
  output logic [pfa_pkg::PID_W-1:0]       out_evicted_process,
  output logic [pfa_pkg::MS_W-1:0]        out_evicted_bytes,
  output logic [pfa_pkg::MS_W-1:0]        out_active_bytes,
  output logic                            out_last
);

  localparam int FW  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CW  = $clog2(NUM_FRAMES + 1);
  localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PW  = $clog2(MAX_PAGES + 1);
  localparam int PIW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int OW  = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
  localparam int MW  = (CW > PW) ? CW : PW;
  localparam int PF_DEPTH  = NUM_SLOTS << PIW;
  localparam int RST_RAW   = pfa_pkg::DEF_MEMORY_SIZE / pfa_pkg::DEF_PAGE_SIZE;
  localparam int RST_FRAMES = (RST_RAW > NUM_FRAMES) ? NUM_FRAMES : RST_RAW;

  typedef enum logic [4:0] {
    S_IDLE, S_CFG_GO, S_CFG_WAIT, S_DIV_GO, S_DIV_WAIT, S_PAGES, S_EV_CHECK,
    S_SCAN, S_PICK, S_REL_RD, S_REL_WR, S_REL_OWN, S_REL_CHK, S_FIND, S_MAP_RD,
    S_MAP_WR, S_SET, S_RUN_RD, S_RUN_SET, S_MUL_EV, S_MUL_ACT, S_EMIT
  } state_t;

  typedef struct packed {
    pfa_pkg::kind_t                kind;
    logic [pfa_pkg::HANDLE_W-1:0]  handle;
    logic [pfa_pkg::PID_W-1:0]     proc_id;
    logic                          last;
  } res_t;

  function automatic res_t mk_res(pfa_pkg::kind_t kind,
                                  logic [pfa_pkg::HANDLE_W-1:0] handle,
                                  logic [pfa_pkg::PID_W-1:0] proc_id, logic last);
    res_t r;
    r.kind    = kind;
    r.handle  = handle;
    r.proc_id = proc_id;
    r.last    = last;
    return r;
  endfunction

  state_t                        state_r;
  logic [pfa_pkg::PS_W-1:0]      ps_r;
  logic [pfa_pkg::MS_W-1:0]      ms_r;
  logic [pfa_pkg::PS_W-1:0]      eff_ps;

  logic [FW-1:0]                 head_r;
  logic [CW-1:0]                 count_r;
  logic [NUM_FRAMES-1:0]         written_r;
  logic [NUM_SLOTS-1:0]          slot_valid_r;
  logic [NUM_SLOTS-1:0]          slot_run_r;
  logic [pfa_pkg::AGE_W-1:0]     slot_age_r   [NUM_SLOTS];
  logic [pfa_pkg::PID_W-1:0]     slot_owner_r [NUM_SLOTS];
  logic [PW-1:0]                 slot_pages_r [NUM_SLOTS];
  logic [NUM_PROCESSES-1:0]      owner_valid_r;
  logic [pfa_pkg::AGE_W-1:0]     age_cnt_r;
  logic [CW-1:0]                 total_r;

  logic [1:0]                    act_r;
  logic [pfa_pkg::BYTES_W-1:0]   bytes_r;
  logic [pfa_pkg::PID_W-1:0]     pid_r;
  logic [PW-1:0]                 pages_r;
  logic [SW-1:0]                 idx_r;
  logic                          have_r;
  logic [SW-1:0]                 vic_r;
  logic [pfa_pkg::AGE_W-1:0]     vic_age_r;
  logic [SW-1:0]                 work_slot_r;
  logic [PW-1:0]                 work_n_r;
  logic [PW-1:0]                 work_p_r;
  logic                          evict_r;

  res_t                          res_r;
  logic [pfa_pkg::MS_W-1:0]      res_ebytes_r;
  logic [pfa_pkg::MS_W-1:0]      res_active_r;

  logic                          out_valid_r;
  res_t                          out_res_r;
  logic [pfa_pkg::MS_W-1:0]      out_ebytes_r;
  logic [pfa_pkg::MS_W-1:0]      out_active_r;

  logic [FW-1:0]                 fifo_mem [NUM_FRAMES];
  logic [FW-1:0]                 fifo_rdata_r;
  logic                          fifo_rwr_r;
  logic [FW-1:0]                 fifo_ridx_r;
  logic [FW-1:0]                 fifo_val;
  logic [FW-1:0]                 pf_mem [PF_DEPTH];
  logic [FW-1:0]                 pf_rdata_r;
  logic [SW+PIW-1:0]             pf_addr;
  logic [SW-1:0]                 own_mem [NUM_PROCESSES];
  logic [SW-1:0]                 own_rdata_r;
  logic [OW-1:0]                 own_raddr;
  logic [OW-1:0]                 rel_own_idx;
  logic                          rel_own_ok;
  logic                          pid_ok;

  logic [CW:0]                   tail_sum;
  logic [FW-1:0]                 tail;
  logic                          fifo_we;
  logic                          own_we;
  logic                          pf_we;
  logic                          free_found;
  logic [SW-1:0]                 free_idx;
  logic                          take;
  logic                          out_free;
  logic                          in_xfer;
  logic                          cfg_xfer;
  logic                          too_big;
  logic [PW-1:0]                 pages_calc;
  logic [MW-1:0]                 mul_a;
  logic [MW+pfa_pkg::PS_W-1:0]   prod;
  logic [CW-1:0]                 frames_calc;

  pfa_pkg::div_req_t             div_req;
  pfa_pkg::div_rsp_t             div_rsp;

  pfa_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign eff_ps = (ps_r == '0) ? pfa_pkg::PS_W'(1) : ps_r;

  assign div_req.start    = (state_r == S_CFG_GO) || (state_r == S_DIV_GO);
  assign div_req.dividend = (state_r == S_CFG_GO) ? pfa_pkg::DIV_W'(ms_r) : bytes_r;
  assign div_req.divisor  = eff_ps;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !in_valid;
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;

  assign tail_sum = (CW+1)'(head_r) + (CW+1)'(count_r);
  assign tail     = (tail_sum >= (CW+1)'(NUM_FRAMES)) ? FW'(tail_sum - (CW+1)'(NUM_FRAMES))
                                                      : FW'(tail_sum);
  assign fifo_val = fifo_rwr_r ? fifo_rdata_r : fifo_ridx_r;
  assign pf_addr  = {work_slot_r, work_p_r[PIW-1:0]};

  assign rel_own_idx = OW'(slot_owner_r[work_slot_r]);
  assign rel_own_ok  = 32'(slot_owner_r[work_slot_r]) < NUM_PROCESSES;
  assign pid_ok      = 32'(pid_r) < NUM_PROCESSES;
  assign own_raddr   = (state_r == S_REL_OWN) ? rel_own_idx : OW'(pid_r);

  assign fifo_we = (state_r == S_REL_WR) && (count_r < CW'(NUM_FRAMES));
  assign pf_we   = (state_r == S_MAP_WR);
  assign own_we  = (state_r == S_SET) && pid_ok;

  assign too_big = (div_rsp.quot > pfa_pkg::DIV_W'(MAX_PAGES)) ||
                   ((div_rsp.quot == pfa_pkg::DIV_W'(MAX_PAGES)) && (div_rsp.rem != '0));
  assign pages_calc = PW'(div_rsp.quot) + PW'(div_rsp.rem != '0);
  assign frames_calc = (div_rsp.quot > pfa_pkg::DIV_W'(NUM_FRAMES)) ? CW'(NUM_FRAMES)
                                                                    : CW'(div_rsp.quot);

  assign take = slot_valid_r[idx_r] && !slot_run_r[idx_r] &&
                (!have_r || (slot_age_r[idx_r] < vic_age_r));

  assign mul_a = (state_r == S_MUL_EV) ? MW'(work_n_r) : MW'(total_r);
  assign prod  = (MW+pfa_pkg::PS_W)'(mul_a) * (MW+pfa_pkg::PS_W)'(eff_ps);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // frame free list
  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[tail] <= pf_rdata_r;
    end
    fifo_rdata_r <= fifo_mem[head_r];
    fifo_rwr_r   <= written_r[head_r];
    fifo_ridx_r  <= head_r;
  end

  // page to frame map
  always_ff @(posedge clk) begin
    if (pf_we) begin
      pf_mem[pf_addr] <= fifo_val;
    end
    pf_rdata_r <= pf_mem[pf_addr];
  end

  // process to slot lookup
  always_ff @(posedge clk) begin
    if (own_we) begin
      own_mem[OW'(pid_r)] <= work_slot_r;
    end
    own_rdata_r <= own_mem[own_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      ps_r          <= pfa_pkg::PS_W'(pfa_pkg::DEF_PAGE_SIZE);
      ms_r          <= pfa_pkg::MS_W'(pfa_pkg::DEF_MEMORY_SIZE);
      head_r        <= '0;
      count_r       <= CW'(RST_FRAMES);
      written_r     <= '0;
      slot_valid_r  <= '0;
      slot_run_r    <= '0;
      owner_valid_r <= '0;
      age_cnt_r     <= '0;
      total_r       <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_pages_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cfg_xfer) begin
            if (cfg_index == pfa_pkg::REG_PAGE_SIZE) begin
              ps_r <= cfg_data[pfa_pkg::PS_W-1:0];
            end else begin
              ms_r <= cfg_data;
            end
            state_r <= S_CFG_GO;
          end else if (in_xfer) begin
            act_r        <= in_action;
            bytes_r      <= in_request_bytes;
            pid_r        <= in_process_id;
            res_ebytes_r <= '0;
            unique case (in_action)
              pfa_pkg::ACT_ALLOC: state_r <= S_DIV_GO;
              pfa_pkg::ACT_FREE: begin
                res_r <= mk_res(pfa_pkg::KIND_ACK, in_handle_in, '0, 1'b1);
                if ((32'(in_handle_in) < NUM_SLOTS) && slot_valid_r[SW'(in_handle_in)]) begin
                  work_slot_r <= SW'(in_handle_in);
                  work_n_r    <= slot_pages_r[SW'(in_handle_in)];
                  work_p_r    <= '0;
                  evict_r     <= 1'b0;
                  state_r     <= S_REL_RD;
                end else begin
                  state_r <= S_MUL_ACT;
                end
              end
              default: state_r <= S_RUN_RD;
            endcase
          end
        end
        S_CFG_GO:   state_r <= S_CFG_WAIT;
        S_CFG_WAIT: begin
          if (div_rsp.done) begin
            count_r       <= frames_calc;
            head_r        <= '0;
            written_r     <= '0;
            slot_valid_r  <= '0;
            slot_run_r    <= '0;
            owner_valid_r <= '0;
            age_cnt_r     <= '0;
            total_r       <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
              slot_pages_r[i] <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        S_DIV_GO:   state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            state_r <= S_PAGES;
          end
        end
        S_PAGES: begin
          if (too_big) begin
            res_r   <= mk_res(pfa_pkg::KIND_FAIL, '0, '0, 1'b1);
            state_r <= S_MUL_ACT;
          end else begin
            pages_r <= pages_calc;
            state_r <= S_EV_CHECK;
          end
        end
        S_EV_CHECK: begin
          res_ebytes_r <= '0;
          if (32'(count_r) >= 32'(pages_r)) begin
            state_r <= S_FIND;
          end else begin
            idx_r   <= '0;
            have_r  <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (take) begin
            have_r    <= 1'b1;
            vic_r     <= idx_r;
            vic_age_r <= slot_age_r[idx_r];
          end
          if (idx_r == SW'(NUM_SLOTS - 1)) begin
            state_r <= S_PICK;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_PICK: begin
          if (have_r) begin
            res_r       <= mk_res(pfa_pkg::KIND_EVICT, pfa_pkg::HANDLE_W'(vic_r),
                                  slot_owner_r[vic_r], 1'b0);
            work_slot_r <= vic_r;
            work_n_r    <= slot_pages_r[vic_r];
            work_p_r    <= '0;
            evict_r     <= 1'b1;
            state_r     <= S_REL_RD;
          end else begin
            res_r   <= mk_res(pfa_pkg::KIND_FAIL, '0, '0, 1'b1);
            state_r <= S_MUL_ACT;
          end
        end
        S_REL_RD: begin
          state_r <= (work_p_r < work_n_r) ? S_REL_WR : S_REL_OWN;
        end
        S_REL_WR: begin
          if (fifo_we) begin
            written_r[tail] <= 1'b1;
            count_r         <= count_r + 1'b1;
          end
          work_p_r <= work_p_r + 1'b1;
          state_r  <= S_REL_RD;
        end
        S_REL_OWN: state_r <= S_REL_CHK;
        S_REL_CHK: begin
          if (rel_own_ok && owner_valid_r[rel_own_idx] && (own_rdata_r == work_slot_r)) begin
            owner_valid_r[rel_own_idx] <= 1'b0;
          end
          slot_valid_r[work_slot_r] <= 1'b0;
          slot_run_r[work_slot_r]   <= 1'b0;
          slot_pages_r[work_slot_r] <= '0;
          total_r <= total_r - CW'(work_n_r);
          state_r <= evict_r ? S_MUL_EV : S_MUL_ACT;
        end
        S_FIND: begin
          if (free_found) begin
            work_slot_r <= free_idx;
            work_p_r    <= '0;
            state_r     <= S_MAP_RD;
          end else begin
            res_r   <= mk_res(pfa_pkg::KIND_FAIL, '0, '0, 1'b1);
            state_r <= S_MUL_ACT;
          end
        end
        S_MAP_RD: begin
          state_r <= (work_p_r < pages_r) ? S_MAP_WR : S_SET;
        end
        S_MAP_WR: begin
          head_r   <= (head_r == FW'(NUM_FRAMES - 1)) ? '0 : head_r + 1'b1;
          count_r  <= count_r - 1'b1;
          work_p_r <= work_p_r + 1'b1;
          state_r  <= S_MAP_RD;
        end
        S_SET: begin
          slot_valid_r[work_slot_r] <= 1'b1;
          slot_run_r[work_slot_r]   <= 1'b0;
          slot_age_r[work_slot_r]   <= age_cnt_r;
          slot_owner_r[work_slot_r] <= pid_r;
          slot_pages_r[work_slot_r] <= pages_r;
          age_cnt_r <= age_cnt_r + 1'b1;
          total_r   <= total_r + CW'(pages_r);
          if (pid_ok) begin
            owner_valid_r[OW'(pid_r)] <= 1'b1;
          end
          res_r   <= mk_res(pfa_pkg::KIND_DONE, pfa_pkg::HANDLE_W'(work_slot_r), '0, 1'b1);
          state_r <= S_MUL_ACT;
        end
        S_RUN_RD: begin
          res_r <= mk_res(pfa_pkg::KIND_ACK, '0, '0, 1'b1);
          state_r <= (pid_ok && owner_valid_r[OW'(pid_r)]) ? S_RUN_SET : S_MUL_ACT;
        end
        S_RUN_SET: begin
          if (slot_valid_r[own_rdata_r]) begin
            slot_run_r[own_rdata_r] <= (act_r == pfa_pkg::ACT_RUN);
          end
          state_r <= S_MUL_ACT;
        end
        S_MUL_EV: begin
          res_ebytes_r <= pfa_pkg::MS_W'(prod);
          state_r      <= S_MUL_ACT;
        end
        S_MUL_ACT: begin
          res_active_r <= pfa_pkg::MS_W'(prod);
          state_r      <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_res_r    <= res_r;
            out_ebytes_r <= res_ebytes_r;
            out_active_r <= res_active_r;
            state_r      <= res_r.last ? S_IDLE : S_EV_CHECK;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_res_r.kind;
  assign out_handle_out      = out_res_r.handle;
  assign out_evicted_process = out_res_r.proc_id;
  assign out_evicted_bytes   = out_ebytes_r;
  assign out_active_bytes    = out_active_r;
  assign out_last            = out_res_r.last;

endmodule

// File: rtl/pfa_checker.sv
// port-level checks of the paged frame allocator, bound to the top level
module pfa_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          cfg_ready,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    out_kind,
  input logic [pfa_pkg::HANDLE_W-1:0]  out_handle_out,
  input logic [pfa_pkg::PID_W-1:0]     out_evicted_process,
  input logic [pfa_pkg::MS_W-1:0]      out_evicted_bytes,
  input logic                          out_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
    $stable(out_evicted_bytes) && $stable(out_last))
    else $error("stalled result changed");

  // one item at a time
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  a_cfg_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !in_stall)
    else $error("config ready while busy");

  // eviction is never the final result
  a_evict_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == pfa_pkg::KIND_EVICT |-> !out_last)
    else $error("eviction marked last");

  a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == pfa_pkg::KIND_FAIL |->
    out_last && out_evicted_bytes == '0 && out_evicted_process == '0 &&
    out_handle_out == '0)
    else $error("failure result with nonzero fields");

endmodule

bind paged_frame_allocator_evict pfa_checker u_pfa_checker (.*);
